// File: hdl/tms_pkg.sv
// Shared types and constants for the thruster mix and slew limiter.
package tms_pkg;

    localparam int NUM_AXES       = 6;
    localparam int AXIS_COUNT_DEF = 6;

    localparam int DEMAND_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = DEMAND_W + GAIN_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int LEVEL_W    = 15;
    localparam int PREV_W     = 16;
    localparam int FRAC_BITS  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = NUM_AXES * DEMAND_W;
    localparam int OUT_DATA_W = 16;

    typedef logic signed [DEMAND_W-1:0] demand_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [PAIR_W-1:0]   pair_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic signed [PREV_W-1:0]   prev_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    typedef logic [NUM_AXES-1:0][PROD_W-1:0] prod_vec_t;

    localparam level_t   LEVEL_MAX  = 15'd25600;
    localparam level_t   RAMP_RESET = 15'd25600;
    localparam prev_t    PREV_RESET = -16'sd256;
    localparam cfg_idx_t CFG_RAMP   = 3'd6;

endpackage

// File: hdl/tms_lane.sv
// One mixing lane: axis demand times gain, registered.
module tms_lane
    import tms_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  demand_t demand,
    input  gain_t   gain,
    output prod_t   prod
);

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_t'(demand) * prod_t'(gain);
        end
    end

    assign prod = prod_reg;

endmodule

// File: hdl/tms_merge.sv
// Registered adder tree over the lane products, floor shift and clamp to target.
module tms_merge
    import tms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  prod_vec_t prods,
    output logic      out_valid,
    input  logic      out_ready,
    output level_t    target
);

    logic   a_valid_reg;
    logic   b_valid_reg;
    logic   c_valid_reg;
    logic   ready_a;
    logic   ready_b;
    logic   ready_c;
    pair_t  pair_reg [3];
    sum_t   total_reg;
    level_t target_reg;
    level_t target_next;
    logic [SUM_W-FRAC_BITS-1:0] shifted;

    assign ready_c  = !c_valid_reg || out_ready;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    assign shifted = total_reg[SUM_W-1:FRAC_BITS];

    always_comb
    begin
        priority if (total_reg[SUM_W-1])
        begin
            target_next = '0;
        end
        else if (shifted > {{(SUM_W-FRAC_BITS-LEVEL_W){1'b0}}, LEVEL_MAX})
        begin
            target_next = LEVEL_MAX;
        end
        else
        begin
            target_next = shifted[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (ready_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (ready_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_a)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pair_reg[i] <= pair_t'($signed(prods[2*i])) + pair_t'($signed(prods[2*i+1]));
            end
        end
        if (a_valid_reg && ready_b)
        begin
            total_reg <= sum_t'(pair_reg[0]) + sum_t'(pair_reg[1]) + sum_t'(pair_reg[2]);
        end
        if (b_valid_reg && ready_c)
        begin
            target_reg <= target_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign target    = target_reg;

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> target_reg <= LEVEL_MAX)
        else $error("merge target above full scale");

endmodule

// File: hdl/tms_slew.sv
// Slew limiter: held drive level, change flag and output register.
module tms_slew
    import tms_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  level_t target,
    input  level_t ramp_step,
    output logic   out_valid,
    input  logic   out_ready,
    output level_t level,
    output logic   changed
);

    level_t cur_reg;
    level_t cur_next;
    prev_t  prev_reg;
    logic   out_valid_reg;
    logic   changed_reg;
    logic   adv;
    level_t diff;

    assign in_ready = !out_valid_reg || out_ready;
    assign adv      = in_valid && in_ready;
    assign diff     = target - cur_reg;

    always_comb
    begin
        priority if (cur_reg < target && diff > ramp_step)
        begin
            cur_next = cur_reg + ramp_step;
        end
        else
        begin
            cur_next = target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            prev_reg      <= PREV_RESET;
            out_valid_reg <= 1'b0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (adv)
            begin
                cur_reg     <= cur_next;
                prev_reg    <= prev_t'({1'b0, cur_next});
                changed_reg <= (prev_reg != prev_t'({1'b0, cur_next}));
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = cur_reg;
    assign changed   = changed_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= LEVEL_MAX)
        else $error("drive level above full scale");

    a_rise_limit: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> ({1'b0, cur_reg} <= {1'b0, $past(cur_reg)} + {1'b0, $past(ramp_step)}))
        else $error("drive level rose faster than ramp step");

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> prev_reg == prev_t'({1'b0, cur_reg}))
        else $error("last given level out of step with output");

endmodule

// File: hdl/thruster_mix_slew_limiter.sv
// Top level: config registers, parallel mixing lanes, merge tree and slew limiter.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: axis_demand_0..5, 16b each
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: drive_level; tuser: level_changed
//  cfg      | in  | cfg_we                       | cfg_index 0..5 gain_n, 6 ramp_step
//
//  One beat per cycle sustained while m_axis_tready stays high; registered stages are
//  lane multiply, two adder tree levels, clamp and slew register.
//  Each pipeline stage has its own valid and ready, so bubbles close up under stall.
//  Reset loads gains 0, ramp_step 25600, level 0, last level -1.0; no clearing pass.
module thruster_mix_slew_limiter
    import tms_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // axis_demand_0 .. axis_demand_5
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // drive_level[14:0], zero pad
    output logic                  m_axis_tuser,   // level_changed
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gain_t     gain_reg [NUM_AXES];
    level_t    ramp_reg;
    logic      lane_valid_reg;
    logic      merge_in_ready;
    logic      in_beat;
    prod_vec_t prods;
    logic      tgt_valid;
    logic      tgt_ready;
    level_t    target;
    level_t    level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gain_reg[i] <= '0;
            end
            ramp_reg <= RAMP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index < cfg_idx_t'(NUM_AXES))
            begin
                gain_reg[cfg_index] <= gain_t'(cfg_data);
            end
            else if (cfg_index == CFG_RAMP)
            begin
                ramp_reg <= cfg_data[LEVEL_W-1:0];
            end
        end
    end

    assign s_axis_tready = !lane_valid_reg || merge_in_ready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            lane_valid_reg <= s_axis_tvalid;
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        if (g < AXIS_COUNT)
        begin : g_used
            prod_t prod;

            tms_lane u_lane (
                .clk    (clk),
                .en     (in_beat),
                .demand (demand_t'(s_axis_tdata[g*DEMAND_W +: DEMAND_W])),
                .gain   (gain_reg[g]),
                .prod   (prod)
            );

            assign prods[g] = prod;
        end
        else
        begin : g_unused
            assign prods[g] = '0;
        end
    end

    tms_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_valid_reg),
        .in_ready  (merge_in_ready),
        .prods     (prods),
        .out_valid (tgt_valid),
        .out_ready (tgt_ready),
        .target    (target)
    );

    tms_slew u_slew (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tgt_valid),
        .in_ready  (tgt_ready),
        .target    (target),
        .ramp_step (ramp_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .level     (level),
        .changed   (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-LEVEL_W){1'b0}}, level};

endmodule

// File: bench/thruster_mix_slew_limiter_tb.sv
// Self-checking testbench for thruster_mix_slew_limiter: stream driver, monitor, predictor.
module thruster_mix_slew_limiter_tb;
    import tms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int       LANES           = AXIS_COUNT_DEF;
    localparam int       RANDOM_PHASES   = 12;
    localparam int       ITEMS_PER_PHASE = 125;
    localparam int       HOLD_CYCLES     = 300;
    localparam int       DRAIN_CYCLES    = 20;
    localparam int       IDLE_LIMIT      = 2000;
    localparam int       MAX_REPORTS     = 10;
    localparam cfg_idx_t CFG_UNUSED      = 3'd7;

    typedef logic [NUM_AXES-1:0][DEMAND_W-1:0] demand_vec_t;

    typedef struct packed {
        level_t level;
        logic   changed;
    } drive_beat_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // axis_demand_0 .. axis_demand_5
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // drive_level[14:0], zero pad
    logic                  m_axis_tuser;         // level_changed
    logic                  cfg_we        = 1'b0;
    cfg_idx_t              cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    demand_vec_t demand_backlog [$];
    drive_beat_t drive_expected [$];

    gain_t  gain_set [NUM_AXES];
    level_t ramp_set;
    level_t level_now;
    prev_t  level_last;

    bit no_gaps = 1'b0;
    int tx_gap = 0;
    int rx_stall = 0;
    int rx_hold = 0;
    int demands_queued = 0;
    int results_checked = 0;
    int fault_count = 0;
    int flags_set = 0;
    int flags_clear = 0;
    int holds_done = 0;
    int settings_used = 0;
    int reg_writes = 0;

    thruster_mix_slew_limiter #(
        .AXIS_COUNT (LANES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic drive_beat_t mix_and_slew(demand_vec_t dv);
        longint      acc;
        longint      tgt;
        demand_t     d;
        drive_beat_t beat;
        acc = 0;
        for (int a = 0; a < LANES; a++)
        begin
            d = dv[a];
            acc += longint'(d) * longint'(gain_set[a]);
        end
        if (acc < 0)
            tgt = 0;
        else
            tgt = acc >>> FRAC_BITS;
        if (tgt > longint'(LEVEL_MAX))
            tgt = longint'(LEVEL_MAX);
        if (longint'(level_now) < tgt)
        begin
            if (tgt - longint'(level_now) > longint'(ramp_set))
                level_now = level_now + ramp_set;
            else
                level_now = level_t'(tgt);
        end
        else
        begin
            level_now = level_t'(tgt);
        end
        beat.level   = level_now;
        beat.changed = (prev_t'(level_now) != level_last);
        level_last   = prev_t'(level_now);
        return beat;
    endfunction

    function automatic demand_vec_t vec_all(logic [DEMAND_W-1:0] val);
        demand_vec_t v;
        for (int a = 0; a < NUM_AXES; a++)
            v[a] = val;
        return v;
    endfunction

    function automatic demand_vec_t vec_one(logic [DEMAND_W-1:0] val);
        demand_vec_t v;
        v    = '0;
        v[0] = val;
        return v;
    endfunction

    function automatic logic [DEMAND_W-1:0] edge_value();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic demand_vec_t pick_demands(demand_vec_t prior);
        demand_vec_t v;
        int          mode;
        mode = $urandom_range(0, 99);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (mode < 35)
                v[a] = DEMAND_W'($urandom_range(0, 8191) - 4096);
            else if (mode < 55)
                v[a] = DEMAND_W'($urandom);
            else if (mode < 65)
                v[a] = DEMAND_W'($urandom_range(0, 1023) - 512);
            else if (mode < 75)
                v[a] = edge_value();
            else
                v[a] = prior[a];
        end
        if (mode >= 95)
            v = '0;
        return v;
    endfunction

    task automatic queue_demand(demand_vec_t v);
        demand_backlog.push_back(v);
        demands_queued++;
    endtask

    task automatic settle();
        while (results_checked != demands_queued)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        reg_writes++;
        if (idx < NUM_AXES)
            gain_set[idx] = gain_t'(val);
        else if (idx == CFG_RAMP)
            ramp_set = val[LEVEL_W-1:0];
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap        <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                drive_expected.push_back(mix_and_slew(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap        <= tx_gap - 1;
                end
                else if (demand_backlog.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= demand_backlog.pop_front();
                    tx_gap        <= no_gaps ? 0 : $urandom_range(0, 15);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : drive_monitor
        drive_beat_t want;
        int          next_stall;
        int          next_hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
            rx_hold       <= 0;
        end
        else
        begin
            next_stall = rx_stall;
            next_hold  = rx_hold;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (m_axis_tuser)
                    flags_set++;
                else
                    flags_clear++;
                if (drive_expected.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("unexpected drive beat: level %0d changed %0b",
                                 m_axis_tdata[LEVEL_W-1:0], m_axis_tuser);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    results_checked++;
                    if (m_axis_tdata[LEVEL_W-1:0] !== want.level ||
                        m_axis_tuser !== want.changed)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display({"drive beat %0d: expected level %0d changed %0b,",
                                      " got level %0d changed %0b"},
                                     results_checked, want.level, want.changed,
                                     m_axis_tdata[LEVEL_W-1:0], m_axis_tuser);
                    end
                    if (results_checked == 400 || results_checked == 1100)
                    begin
                        next_hold = HOLD_CYCLES;
                        holds_done++;
                    end
                end
                next_stall = no_gaps ? 0 : $urandom_range(0, 15);
            end
            if (next_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold       <= next_hold - 1;
                rx_stall      <= next_stall;
            end
            else if (next_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold       <= 0;
                rx_stall      <= next_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_hold       <= 0;
                rx_stall      <= 0;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        demand_vec_t           v;
        demand_vec_t           last_vec;
        logic [CFG_DATA_W-1:0] word;
        int                    style;
        for (int a = 0; a < NUM_AXES; a++)
            gain_set[a] = '0;
        ramp_set   = RAMP_RESET;
        level_now  = '0;
        level_last = PREV_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset gains: first beat flags against the -1.0 start
        queue_demand(vec_all(16'h0000));
        queue_demand(vec_all(16'h7FFF));
        settle();

        // most negative gains, ramp beyond full scale, stray register index
        for (int a = 0; a < NUM_AXES; a++)
            write_reg(cfg_idx_t'(a), 16'h8000);
        write_reg(CFG_RAMP, 16'h7FFF);
        write_reg(CFG_UNUSED, 16'h1234);
        finish_writes();
        queue_demand(vec_all(16'h8000));
        queue_demand(vec_all(16'h7FFF));
        queue_demand(vec_all(16'h8000));
        queue_demand(vec_all(16'hFFFF));
        settle();

        // floor rounding and a sum of -1
        write_reg(cfg_idx_t'(0), 16'h0001);
        for (int a = 1; a < NUM_AXES; a++)
            write_reg(cfg_idx_t'(a), 16'h0000);
        write_reg(CFG_RAMP, 16'd25600);
        finish_writes();
        queue_demand(vec_one(16'd511));
        queue_demand(vec_one(16'hFFFF));
        queue_demand(vec_one(16'd256));
        queue_demand(vec_one(16'd257));
        settle();

        // unit gains, slow ramp up, instant drop, clamp at full scale
        for (int a = 0; a < NUM_AXES; a++)
            write_reg(cfg_idx_t'(a), 16'h0100);
        write_reg(CFG_RAMP, 16'd1000);
        finish_writes();
        repeat (4) queue_demand(vec_one(16'd25600));
        queue_demand(vec_one(16'd2500));
        v    = vec_one(16'h7FFF);
        v[1] = 16'h7FFF;
        queue_demand(v);
        settle();

        // zero ramp: the level can only fall
        write_reg(CFG_RAMP, 16'd0);
        finish_writes();
        queue_demand(vec_one(16'd25600));
        queue_demand(vec_one(16'd100));
        queue_demand(vec_one(16'd25600));
        last_vec = vec_one(16'd25600);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            style = $urandom_range(0, 3);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                case (style)
                    0:       word = CFG_DATA_W'($urandom_range(0, 768) - 384);
                    1:       word = CFG_DATA_W'($urandom);
                    2:       word = ($urandom_range(0, 1) == 0) ?
                                    edge_value() : CFG_DATA_W'($urandom_range(0, 512));
                    default: word = CFG_DATA_W'($urandom_range(0, 512));
                endcase
                write_reg(cfg_idx_t'(a), word);
            end
            case ($urandom_range(0, 6))
                0:       word = 16'd0;
                1:       word = 16'd1;
                2:       word = 16'd25600;
                3:       word = 16'h7FFF;
                4:       word = CFG_DATA_W'($urandom);
                default: word = CFG_DATA_W'($urandom_range(1, 3000));
            endcase
            write_reg(CFG_RAMP, word);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            finish_writes();
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                last_vec = pick_demands(last_vec);
                queue_demand(last_vec);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d demand beats checked under %0d register settings (%0d writes)",
                 results_checked, settings_used, reg_writes);
        $display("%0d long output holds; level_changed set %0d times, clear %0d times",
                 holds_done, flags_set, flags_clear);
        if (fault_count == 0 && drive_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/tms_pkg.sv
hdl/tms_lane.sv
hdl/tms_merge.sv
hdl/tms_slew.sv
hdl/thruster_mix_slew_limiter.sv
bench/thruster_mix_slew_limiter_tb.sv
